@@ rtl/core/pkw_pkg.sv @@
// Shared constants, types and table-building functions of the kernel weight block.
package pkw_pkg;

    localparam int MAX_SCALES_DEF     = 8;
    localparam int EXP_TABLE_BITS_DEF = 8;

    localparam int LOG_W = 24;  // log2 values, 16 fraction bits
    localparam int LSI_W = 30;  // per-scale log sigma
    localparam int D2_W  = 51;  // squared distance plus shift
    localparam int Y_W   = 48;  // exp2 argument
    localparam int E_W   = 41;  // exp2 result, capped at 2^40
    localparam int ACC_W = 46;  // weight before saturation

    localparam int MID_DEPTH = 8;
    localparam int OUT_DEPTH = 16;

    localparam logic [1:0] MODE_GAUSS    = 2'd0;
    localparam logic [1:0] MODE_MULTI    = 2'd1;
    localparam logic [1:0] MODE_SINGULAR = 2'd2;
    localparam logic [1:0] MODE_ONE      = 2'd3;

    localparam logic [2:0] REG_KERNEL_MODE  = 3'd0;
    localparam logic [2:0] REG_SINGLE_SIGMA = 3'd1;
    localparam logic [2:0] REG_POWER_EXP    = 3'd2;
    localparam logic [2:0] REG_WEIGHT_SHIFT = 3'd3;
    localparam logic [2:0] REG_SCALE_COUNT  = 3'd4;
    localparam logic [2:0] REG_FIRST_SIGMA  = 3'd5;
    localparam logic [2:0] REG_SCALE_RATIO  = 3'd6;

    localparam logic [16:0]      LOG2E_Q16 = 17'd94548;
    localparam logic [31:0]      TINY_RAW  = 32'd7;
    localparam logic [ACC_W-1:0] ONE_Q16   = ACC_W'(65536);
    localparam logic [E_W-1:0]   EXP2_CAP  = E_W'(1) << 40;

    typedef struct packed {
        logic [1:0]              mode;
        logic [31:0]             shift;
        logic [15:0]             pexp;
        logic [3:0]              scount;
        logic signed [LOG_W-1:0] ls;
        logic signed [LOG_W-1:0] lr;
        logic signed [LOG_W-1:0] lv;
    } cfg_t;

    typedef struct packed {
        logic [D2_W-1:0] x;
        logic            d2z;
        logic            denz;
    } mid_item_t;

    typedef struct packed {
        logic                    last;
        logic                    nterm;
        logic                    d2z;
        logic                    denz;
        logic signed [LSI_W-1:0] lsi;
    } slot_t;

    typedef struct packed {
        logic [31:0] weight;
        logic        sat;
    } out_item_t;

    // log2 of m/2^31, m in [2^31, 2^32), 32 fraction bits, by repeated squaring
    function automatic logic [63:0] exact_log2(input logic [63:0] m);
        logic [63:0] y;
        logic [63:0] r;
        y = m;
        r = '0;
        for (int k = 0; k < 32; k++) begin
            y = (y * y) >> 31;
            r = r << 1;
            if (y >= 64'h1_0000_0000) begin
                r = r | 64'd1;
                y = y >> 1;
            end
        end
        return r;
    endfunction

    function automatic logic [16:0] log_entry(input int tb, input int i);
        logic [63:0] m;
        logic [63:0] v;
        if (i == (1 << tb)) begin
            return 17'd65536;
        end
        m = (64'd1 << 31) + (64'(i) << (31 - tb));
        v = (exact_log2(m) + 64'd32768) >> 16;
        return v[16:0];
    endfunction

    function automatic logic [31:0] exp_entry(input int tb, input int i);
        logic [63:0] t;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        if (i == (1 << tb)) begin
            return 32'h8000_0000;
        end
        t  = 64'(i) << (32 - tb);
        lo = 64'd1 << 31;
        hi = 64'd1 << 32;
        while (hi - lo > 64'd1) begin
            mid = (lo + hi) >> 1;
            if (exact_log2(mid) <= t) begin
                lo = mid;
            end else begin
                hi = mid;
            end
        end
        return lo[32:1];
    endfunction

endpackage

@@ rtl/core/point_kernel_weight.sv @@
// Top level of the point-pair kernel weight block.
//
// Takes a query/sample point pair (signed Q16.16) and returns one unsigned Q16.16
// kernel weight plus a saturation flag per request. The input side looks like a
// queue (push/full), the result side too (empty/pop). Gaussian, singular and
// constant modes take one request per cycle while the queues have room;
// multi-scale gaussian runs max(1, min(scale_count, MAX_SCALES)) ladder scales
// per request, since the shared exp2 pipeline evaluates one ladder scale per
// cycle. Registers are written through cfg_valid/cfg_ready (always ready) and
// must only change while no request is in flight; derived sigma logarithms
// settle once a write has passed through the registered log2 units.
module point_kernel_weight
    import pkw_pkg::*;
#(
    parameter int MAX_SCALES     = MAX_SCALES_DEF,
    parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // request queue
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] query_x,
    input  logic signed [31:0] query_y,
    input  logic signed [31:0] query_z,
    input  logic signed [31:0] sample_x,
    input  logic signed [31:0] sample_y,
    input  logic signed [31:0] sample_z,
    // result queue
    output logic               empty,
    input  logic               pop,
    output logic [31:0]        weight,
    output logic               saturated,
    // register writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    // configuration registers
    logic [1:0]  kernel_mode_reg;
    logic [31:0] single_sigma_reg;
    logic [15:0] power_exponent_reg;
    logic [31:0] weight_shift_reg;
    logic [3:0]  scale_count_reg;
    logic [31:0] first_scale_sigma_reg;
    logic [31:0] scale_ratio_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_mode_reg       <= MODE_GAUSS;
            single_sigma_reg      <= 32'd131072;
            power_exponent_reg    <= 16'd256;
            weight_shift_reg      <= 32'd0;
            scale_count_reg       <= 4'd0;
            first_scale_sigma_reg <= 32'd65536;
            scale_ratio_reg       <= 32'd131072;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_KERNEL_MODE:  kernel_mode_reg       <= cfg_data[1:0];
                REG_SINGLE_SIGMA: single_sigma_reg      <= cfg_data;
                REG_POWER_EXP:    power_exponent_reg    <= cfg_data[15:0];
                REG_WEIGHT_SHIFT: weight_shift_reg      <= cfg_data;
                REG_SCALE_COUNT:  scale_count_reg       <= cfg_data[3:0];
                REG_FIRST_SIGMA:  first_scale_sigma_reg <= cfg_data;
                REG_SCALE_RATIO:  scale_ratio_reg       <= cfg_data;
                default:          ;
            endcase
        end
    end

    // logs of the register values; only the sigma of the active mode is needed
    logic [31:0]             sigma_sel, tiny_val;
    logic signed [LOG_W-1:0] ls, lr, lv;

    assign sigma_sel = (kernel_mode_reg == MODE_GAUSS) ? single_sigma_reg
                                                        : first_scale_sigma_reg;
    assign tiny_val  = (weight_shift_reg > TINY_RAW) ? weight_shift_reg : TINY_RAW;

    pkw_log2 #(.WIDTH(32), .TBITS(EXP_TABLE_BITS)) u_log_sigma (
        .clk (clk), .x (sigma_sel), .y (ls)
    );
    pkw_log2 #(.WIDTH(32), .TBITS(EXP_TABLE_BITS)) u_log_ratio (
        .clk (clk), .x (scale_ratio_reg), .y (lr)
    );
    pkw_log2 #(.WIDTH(32), .TBITS(EXP_TABLE_BITS)) u_log_tiny (
        .clk (clk), .x (tiny_val), .y (lv)
    );

    cfg_t cfg;

    always_comb
    begin
        cfg.mode   = kernel_mode_reg;
        cfg.shift  = weight_shift_reg;
        cfg.pexp   = power_exponent_reg;
        cfg.scount = scale_count_reg;
        cfg.ls     = ls;
        cfg.lr     = lr;
        cfg.lv     = lv;
    end

    // front end and the queue to the back end
    logic                       mid_push, mid_pop, mid_empty;
    mid_item_t                  mid_wdata, mid_head;
    logic [$bits(mid_item_t)-1:0] mid_rdata;
    logic [$clog2(MID_DEPTH):0] mid_count;

    pkw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .push      (push),
        .full      (full),
        .query_x   (query_x),
        .query_y   (query_y),
        .query_z   (query_z),
        .sample_x  (sample_x),
        .sample_y  (sample_y),
        .sample_z  (sample_z),
        .mid_count (mid_count),
        .mid_push  (mid_push),
        .mid_data  (mid_wdata)
    );

    pkw_fifo #(.WIDTH($bits(mid_item_t)), .DEPTH(MID_DEPTH)) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (mid_wdata),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty),
        .count (mid_count)
    );

    assign mid_head = mid_item_t'(mid_rdata);

    // back end; it only starts a request when the result queue has room for it
    logic                         out_push, out_pop;
    out_item_t                    out_wdata, out_head;
    logic [$bits(out_item_t)-1:0] out_rdata;

    assign out_pop = pop && !empty;

    pkw_back #(.MAX_SCALES(MAX_SCALES), .EXP_TABLE_BITS(EXP_TABLE_BITS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head       (mid_head),
        .head_valid (!mid_empty),
        .head_pop   (mid_pop),
        .out_push   (out_push),
        .out_item   (out_wdata),
        .out_pop    (out_pop)
    );

    pkw_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(OUT_DEPTH)) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_wdata),
        .pop   (out_pop),
        .rdata (out_rdata),
        .empty (empty),
        .count ()
    );

    assign out_head  = out_item_t'(out_rdata);
    assign weight    = out_head.weight;
    assign saturated = out_head.sat;

endmodule

@@ rtl/core/pkw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pkw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/pkw_fifo.sv @@
// Show-ahead FIFO on the generic RAM; empty follows a registered copy of push, so an entry shows only after its write.
module pkw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       empty,
    output logic [$clog2(DEPTH):0]     count
);

    localparam int AW = $clog2(DEPTH);

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic [AW:0]   vis_reg, vis_next;
    logic          push_d_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + AW'(push);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        cnt_next    = cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        vis_next    = vis_reg + (AW+1)'(push_d_reg) - (AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            vis_reg    <= '0;
            push_d_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            vis_reg    <= vis_next;
            push_d_reg <= push;
        end
    end

    pkw_ram #(.WIDTH(WIDTH), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (push),
        .waddr (wr_ptr_reg),
        .wdata (wdata),
        .raddr (rd_ptr_next),
        .rdata (rdata)
    );

    assign empty = (vis_reg == '0);
    assign count = cnt_reg;

endmodule

@@ rtl/core/pkw_log2.sv @@
// Two-stage log2 unit: leading-one search, then normalize, table and interpolate.
module pkw_log2
    import pkw_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int TBITS = EXP_TABLE_BITS_DEF
) (
    input  logic                    clk,
    input  logic [WIDTH-1:0]        x,
    output logic signed [LOG_W-1:0] y
);

    localparam int TSIZE = 1 << TBITS;
    localparam int PW    = $clog2(WIDTH);

    logic [16:0] ltab [TSIZE+1];

    for (genvar gi = 0; gi <= TSIZE; gi++) begin : g_tab
        localparam logic [16:0] V = log_entry(TBITS, gi);
        assign ltab[gi] = V;
    end

    logic [WIDTH-1:0] xx;
    logic [PW-1:0]    p_next;
    logic [WIDTH-1:0] x_reg;
    logic [PW-1:0]    p_reg;

    always_comb
    begin
        xx     = (x == '0) ? WIDTH'(1) : x;
        p_next = '0;
        for (int i = 0; i < WIDTH; i++)
        begin
            if (xx[i])
            begin
                p_next = PW'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= xx;
        p_reg <= p_next;
    end

    logic [63:0]             n;
    logic [TBITS-1:0]        idx;
    logic [15:0]             rem;
    logic [16:0]             lo, hi, dl, frac;
    logic [32:0]             dprod;
    logic signed [LOG_W-1:0] pint, y_next;

    always_comb
    begin
        n      = 64'(x_reg) << (63 - int'(p_reg));
        idx    = n[62 -: TBITS];
        rem    = n[62-TBITS -: 16];
        lo     = ltab[{1'b0, idx}];
        hi     = ltab[{1'b0, idx} + (TBITS+1)'(1)];
        dl     = hi - lo;
        dprod  = 33'(dl) * 33'(rem);
        frac   = lo + dprod[32:16];
        pint   = LOG_W'($signed({1'b0, p_reg})) - LOG_W'(16);
        y_next = (pint <<< 16) + LOG_W'(frac);
    end

    always_ff @(posedge clk)
    begin
        y <= y_next;
    end

endmodule

@@ rtl/core/pkw_exp2.sv @@
// One-stage exp2 unit: table plus interpolation, then scale by the integer part.
module pkw_exp2
    import pkw_pkg::*;
#(
    parameter int TBITS = EXP_TABLE_BITS_DEF
) (
    input  logic                  clk,
    input  logic signed [Y_W-1:0] y,
    output logic [E_W-1:0]        q
);

    localparam int TSIZE = 1 << TBITS;
    localparam int RW    = 16 - TBITS;

    logic [31:0] etab [TSIZE+1];

    for (genvar gi = 0; gi <= TSIZE; gi++) begin : g_tab
        localparam logic [31:0] V = exp_entry(TBITS, gi);
        assign etab[gi] = V;
    end

    logic signed [Y_W:0] z, ip, ipm, shr_w;
    logic [TBITS-1:0]    idx;
    logic [RW-1:0]       r;
    logic [31:0]         lo, hi, dl, mant;
    logic [47:0]         dprod;
    logic [3:0]          shl;
    logic [5:0]          shr;
    logic [63:0]         wide;
    logic [E_W-1:0]      q_next;

    always_comb
    begin
        z      = (Y_W+1)'(y) + (Y_W+1)'(1 << 20);
        ip     = z >>> 16;
        idx    = z[15 -: TBITS];
        r      = z[RW-1:0];
        lo     = etab[{1'b0, idx}];
        hi     = etab[{1'b0, idx} + (TBITS+1)'(1)];
        dl     = hi - lo;
        dprod  = 48'(dl) * 48'(r);
        mant   = lo + 32'(dprod >> RW);
        ipm    = ip - 30;
        shl    = ipm[3:0];
        shr_w  = 30 - ip;
        shr    = shr_w[5:0];
        wide   = 64'(mant) >> shr;
        if (ip >= 40)
        begin
            q_next = EXP2_CAP;
        end
        else if (ip >= 30)
        begin
            q_next = E_W'(mant) << shl;
        end
        else if (ip <= -33)
        begin
            q_next = '0;
        end
        else
        begin
            q_next = wide[E_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        q <= q_next;
    end

endmodule

@@ rtl/core/pkw_front.sv @@
// Front end: accepts point pairs, forms squared distance and classifies for the back end.
module pkw_front
    import pkw_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfg_t                          cfg,
    input  logic                          push,
    output logic                          full,
    input  logic signed [31:0]            query_x,
    input  logic signed [31:0]            query_y,
    input  logic signed [31:0]            query_z,
    input  logic signed [31:0]            sample_x,
    input  logic signed [31:0]            sample_y,
    input  logic signed [31:0]            sample_z,
    input  logic [$clog2(MID_DEPTH):0]    mid_count,
    output logic                          mid_push,
    output mid_item_t                     mid_data
);

    localparam int CW = $clog2(MID_DEPTH) + 2;

    logic              accept;
    logic [31:0]       qv [3];
    logic [31:0]       sv [3];
    logic [31:0]       ad_next [3];
    logic [31:0]       ad_reg [3];
    logic              v1_reg, v2_reg;
    logic signed [32:0] d;

    assign full   = (CW'(mid_count) + CW'(v1_reg) + CW'(v2_reg)) >= CW'(MID_DEPTH);
    assign accept = push && !full;

    assign qv[0] = query_x;
    assign qv[1] = query_y;
    assign qv[2] = query_z;
    assign sv[0] = sample_x;
    assign sv[1] = sample_y;
    assign sv[2] = sample_z;

    always_comb
    begin
        d = '0;
        for (int i = 0; i < 3; i++)
        begin
            d          = $signed({qv[i][31], qv[i]}) - $signed({sv[i][31], sv[i]});
            ad_next[i] = d[32] ? 32'(-d) : d[31:0];
        end
    end

    logic [63:0]     sq [3];
    logic [D2_W-1:0] d2, den;
    mid_item_t       item_next;

    always_comb
    begin
        d2 = '0;
        for (int i = 0; i < 3; i++)
        begin
            sq[i] = 64'(ad_reg[i]) * 64'(ad_reg[i]);
            d2    = d2 + D2_W'(sq[i][63:16]);
        end
        den            = d2 + D2_W'(cfg.shift);
        item_next.x    = (cfg.mode == MODE_SINGULAR) ? den : d2;
        item_next.d2z  = (d2 == '0);
        item_next.denz = (den == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ad_reg   <= ad_next;
        mid_data <= item_next;
    end

    assign mid_push = v2_reg;

endmodule

@@ rtl/core/pkw_back.sv @@
// Back end: scale sequencer and log2/exp2 pipeline that forms and accumulates the weight.
module pkw_back
    import pkw_pkg::*;
#(
    parameter int MAX_SCALES     = MAX_SCALES_DEF,
    parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  mid_item_t head,
    input  logic      head_valid,
    output logic      head_pop,
    output logic      out_push,
    output out_item_t out_item,
    input  logic      out_pop
);

    localparam int SW = $clog2(MAX_SCALES + 1);
    localparam int PW = $clog2(OUT_DEPTH + 1);

    // sequencer
    logic [SW-1:0] s_reg, s_next, ns, nslots;
    logic [PW-1:0] pend_reg, pend_next;
    logic          issue, start, last;
    slot_t         slot_now;

    always_comb
    begin
        ns     = (32'(cfg.scount) > MAX_SCALES) ? SW'(MAX_SCALES) : SW'(cfg.scount);
        nslots = (cfg.mode == MODE_MULTI && ns != '0) ? ns : SW'(1);
        last   = (s_reg == nslots - SW'(1));
        start  = head_valid && (s_reg == '0) && (pend_reg < PW'(OUT_DEPTH));
        issue  = start || (head_valid && s_reg != '0);
        s_next = issue ? (last ? '0 : s_reg + SW'(1)) : s_reg;
        pend_next = pend_reg + PW'(start) - PW'(out_pop);
        slot_now.last  = last;
        slot_now.nterm = (cfg.mode == MODE_MULTI) && (ns == '0);
        slot_now.d2z   = head.d2z;
        slot_now.denz  = head.denz;
        slot_now.lsi   = LSI_W'(cfg.ls) + LSI_W'($signed({1'b0, s_reg})) * LSI_W'(cfg.lr);
    end

    assign head_pop = issue && last;

    // pipeline
    logic                    va_reg, vb_reg, vc_reg, vd_reg, ve_reg;
    slot_t                   sa_reg, sb_reg, sc_reg, sd_reg, se_reg;
    logic signed [LOG_W-1:0] lg;
    logic signed [LOG_W:0]   diff_c_reg, diff_next;
    logic signed [Y_W-1:0]   y1, y2_next, y2_reg, g;
    logic [E_W-1:0]          q1, term;
    logic [57:0]             mprod;
    logic signed [41:0]      pprod;
    logic [ACC_W-1:0]        acc_reg, acc_next, total, w;

    pkw_log2 #(.WIDTH(D2_W), .TBITS(EXP_TABLE_BITS)) u_log (
        .clk (clk),
        .x   (head.x),
        .y   (lg)
    );

    always_comb
    begin
        y1        = Y_W'(lg) - Y_W'(65536) - (Y_W'(sb_reg.lsi) <<< 1);
        diff_next = (LOG_W+1)'(cfg.lv) - (LOG_W+1)'(lg);
    end

    pkw_exp2 #(.TBITS(EXP_TABLE_BITS)) u_exp_a (
        .clk (clk),
        .y   (y1),
        .q   (q1)
    );

    always_comb
    begin
        mprod = 58'(q1) * 58'(LOG2E_Q16);
        g     = sc_reg.d2z ? '0 : -$signed(Y_W'(mprod[57:16]));
        pprod = 42'(diff_c_reg) * $signed({26'b0, cfg.pexp});
        case (cfg.mode)
            MODE_MULTI:    y2_next = g - Y_W'(sc_reg.lsi) * Y_W'(3);
            MODE_SINGULAR: y2_next = Y_W'(pprod >>> 8);
            default:       y2_next = g;
        endcase
    end

    pkw_exp2 #(.TBITS(EXP_TABLE_BITS)) u_exp_b (
        .clk (clk),
        .y   (y2_reg),
        .q   (term)
    );

    always_comb
    begin
        total    = acc_reg + (se_reg.nterm ? '0 : ACC_W'(term));
        acc_next = acc_reg;
        if (ve_reg && cfg.mode == MODE_MULTI)
        begin
            acc_next = se_reg.last ? '0 : total;
        end
        case (cfg.mode)
            MODE_GAUSS:    w = ACC_W'(term) + ACC_W'(cfg.shift);
            MODE_MULTI:    w = (total == '0) ? ACC_W'(cfg.shift) : total;
            MODE_SINGULAR:
            begin
                if (se_reg.denz)
                begin
                    w = (cfg.pexp == '0) ? ONE_Q16 : ACC_W'(EXP2_CAP);
                end
                else
                begin
                    w = ACC_W'(term);
                end
            end
            default:       w = ONE_Q16;
        endcase
        out_item.sat    = (w > ACC_W'(32'hFFFF_FFFF));
        out_item.weight = out_item.sat ? 32'hFFFF_FFFF : w[31:0];
    end

    assign out_push = ve_reg && se_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg    <= '0;
            pend_reg <= '0;
            acc_reg  <= '0;
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            vc_reg   <= 1'b0;
            vd_reg   <= 1'b0;
            ve_reg   <= 1'b0;
        end
        else
        begin
            s_reg    <= s_next;
            pend_reg <= pend_next;
            acc_reg  <= acc_next;
            va_reg   <= issue;
            vb_reg   <= va_reg;
            vc_reg   <= vb_reg;
            vd_reg   <= vc_reg;
            ve_reg   <= vd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sa_reg     <= slot_now;
        sb_reg     <= sa_reg;
        sc_reg     <= sb_reg;
        sd_reg     <= sc_reg;
        se_reg     <= sd_reg;
        diff_c_reg <= diff_next;
        y2_reg     <= y2_next;
    end

endmodule

@@ rtl/core/pkw_checker.sv @@
// Port-level checks of the kernel weight block, bound to the top level.
module pkw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        pop,
    input logic        empty,
    input logic [31:0] weight,
    input logic        saturated
);

    logic [7:0] outstanding_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_reg + 8'(push && !full) - 8'(pop && !empty);
        end
    end

    // no result shows without a request behind it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg == 8'd0 |-> empty)
        else $error("result shown with no request outstanding");

    // a flagged result carries the clamped maximum
    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && saturated |-> weight == 32'hFFFF_FFFF)
        else $error("saturated result without maximum weight");

    // a result not taken holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(weight) && $stable(saturated))
        else $error("waiting result changed");

endmodule

bind point_kernel_weight pkw_checker u_pkw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .weight    (weight),
    .saturated (saturated)
);
